FILE: rtl/cpph_pkg.sv
// Package for the canonical peer priority hash: hash request type, mode codes,
// prefix masks and CRC-32C helper functions used to build the XOR networks.
// No dependencies.
package cpph_pkg;

  localparam int PORT_BYTES = 4;
  localparam int V4_BYTES   = 8;
  localparam int V6_BYTES   = 32;
  localparam int MSG_BITS   = 8 * V6_BYTES;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [31:0] V4_MASK_WIDE = 32'hFFFF_5555;
  localparam logic [31:0] V4_MASK_MID  = 32'hFFFF_FF55;
  localparam logic [31:0] V4_MASK_NONE = 32'hFFFF_FFFF;
  localparam logic [63:0] V6_MASK_WIDE = 64'hFFFF_FFFF_5555_5555;
  localparam logic [63:0] V6_MASK_MID  = 64'hFFFF_FFFF_FFFF_5555;
  localparam logic [63:0] V6_MASK_NONE = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] MODE_PORTS = 2'd0;
  localparam logic [1:0] MODE_V4    = 2'd1;
  localparam logic [1:0] MODE_V6    = 2'd2;

  // Byte j of the string to hash sits at msg[8*j +: 8].
  typedef struct packed {
    logic [1:0]          mode;
    logic [MSG_BITS-1:0] msg;
  } hash_req_t;

  // Contribution of one message bit to the CRC register, with a zero start value.
  function automatic logic [31:0] crc_col(input int nbytes, input int bitpos);
    logic [31:0] c;
    c = '0;
    for (int j = 0; j < nbytes; j++) begin
      if (j == (bitpos >> 3)) begin
        c = c ^ (32'd1 << (bitpos & 7));
      end
      for (int k = 0; k < 8; k++) begin
        c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
      end
    end
    return c;
  endfunction

  // CRC of an all-zero string of the given length, final inversion included.
  function automatic logic [31:0] crc_const(input int nbytes);
    logic [31:0] c;
    c = CRC_INIT;
    for (int j = 0; j < nbytes; j++) begin
      for (int k = 0; k < 8; k++) begin
        c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
      end
    end
    return c ^ CRC_INIT;
  endfunction

endpackage

FILE: rtl/cpph_order.sv
// Orders the two endpoints, chooses the prefix mask and lays out the byte
// string to hash. Depends on cpph_pkg.
module cpph_order (
  input  logic                is_ipv6,
  input  logic [63:0]         addr_a_hi,
  input  logic [63:0]         addr_a_lo,
  input  logic [15:0]         port_a,
  input  logic [63:0]         addr_b_hi,
  input  logic [63:0]         addr_b_lo,
  input  logic [15:0]         port_b,
  output cpph_pkg::hash_req_t req
);
  import cpph_pkg::*;

  logic [63:0] ah, al, bh, bl;
  logic [63:0] lo_h, lo_l, hi_h, hi_l;
  logic [63:0] d6, m6;
  logic [31:0] x, y, d4, m4, xm, ym;
  logic [63:0] w0, w2;
  logic [15:0] p_lo, p_hi;
  logic        same, a_gt;

  always_comb begin
    ah = is_ipv6 ? addr_a_hi : 64'd0;
    al = is_ipv6 ? addr_a_lo : {32'd0, addr_a_lo[31:0]};
    bh = is_ipv6 ? addr_b_hi : 64'd0;
    bl = is_ipv6 ? addr_b_lo : {32'd0, addr_b_lo[31:0]};
    same = (ah == bh) && (al == bl);
    a_gt = {ah, al} > {bh, bl};
    lo_h = a_gt ? bh : ah;
    lo_l = a_gt ? bl : al;
    hi_h = a_gt ? ah : bh;
    hi_l = a_gt ? al : bl;

    d6 = lo_h ^ hi_h;
    if (|d6[63:32]) begin
      m6 = V6_MASK_WIDE;
    end else if (|d6[31:16]) begin
      m6 = V6_MASK_MID;
    end else begin
      m6 = V6_MASK_NONE;
    end
    w0 = lo_h & m6;
    w2 = hi_h & m6;

    x  = lo_l[31:0];
    y  = hi_l[31:0];
    d4 = x ^ y;
    if (|d4[31:16]) begin
      m4 = V4_MASK_WIDE;
    end else if (|d4[15:8]) begin
      m4 = V4_MASK_MID;
    end else begin
      m4 = V4_MASK_NONE;
    end
    xm = x & m4;
    ym = y & m4;

    p_lo = (port_a < port_b) ? port_a : port_b;
    p_hi = (port_a < port_b) ? port_b : port_a;

    req.msg = '0;
    if (same) begin
      req.mode          = MODE_PORTS;
      req.msg[7:0]      = p_lo[15:8];
      req.msg[15:8]     = p_lo[7:0];
      req.msg[23:16]    = p_hi[15:8];
      req.msg[31:24]    = p_hi[7:0];
    end else if (is_ipv6) begin
      req.mode = MODE_V6;
      for (int i = 0; i < 8; i++) begin
        req.msg[8*i +: 8]        = w0[8*(7-i) +: 8];
        req.msg[8*(8+i) +: 8]    = lo_l[8*(7-i) +: 8];
        req.msg[8*(16+i) +: 8]   = w2[8*(7-i) +: 8];
        req.msg[8*(24+i) +: 8]   = hi_l[8*(7-i) +: 8];
      end
    end else begin
      req.mode = MODE_V4;
      for (int i = 0; i < 4; i++) begin
        req.msg[8*i +: 8]     = xm[8*(3-i) +: 8];
        req.msg[8*(4+i) +: 8] = ym[8*(3-i) +: 8];
      end
    end
  end

endmodule

FILE: rtl/cpph_crc.sv
// CRC-32C of a 4, 8 or 32 byte string as fixed XOR networks, one per length.
// Depends on cpph_pkg.
module cpph_crc (
  input  cpph_pkg::hash_req_t req,
  output logic [31:0]         crc
);
  import cpph_pkg::*;

  localparam logic [31:0] K_PORTS = crc_const(PORT_BYTES);
  localparam logic [31:0] K_V4    = crc_const(V4_BYTES);
  localparam logic [31:0] K_V6    = crc_const(V6_BYTES);

  logic [31:0] tp [8*PORT_BYTES];
  logic [31:0] t4 [8*V4_BYTES];
  logic [31:0] t6 [8*V6_BYTES];
  logic [31:0] crc_p, crc_4, crc_6;

  for (genvar i = 0; i < 8 * PORT_BYTES; i++) begin : g_p
    localparam logic [31:0] COL = crc_col(PORT_BYTES, i);
    assign tp[i] = req.msg[i] ? COL : 32'd0;
  end
  for (genvar i = 0; i < 8 * V4_BYTES; i++) begin : g_4
    localparam logic [31:0] COL = crc_col(V4_BYTES, i);
    assign t4[i] = req.msg[i] ? COL : 32'd0;
  end
  for (genvar i = 0; i < 8 * V6_BYTES; i++) begin : g_6
    localparam logic [31:0] COL = crc_col(V6_BYTES, i);
    assign t6[i] = req.msg[i] ? COL : 32'd0;
  end

  always_comb begin
    crc_p = K_PORTS;
    crc_4 = K_V4;
    crc_6 = K_V6;
    for (int i = 0; i < 8 * PORT_BYTES; i++) begin
      crc_p = crc_p ^ tp[i];
    end
    for (int i = 0; i < 8 * V4_BYTES; i++) begin
      crc_4 = crc_4 ^ t4[i];
    end
    for (int i = 0; i < 8 * V6_BYTES; i++) begin
      crc_6 = crc_6 ^ t6[i];
    end
    case (req.mode)
      MODE_PORTS: crc = crc_p;
      MODE_V4:    crc = crc_4;
      MODE_V6:    crc = crc_6;
      default:    crc = crc_p;
    endcase
  end

endmodule

FILE: rtl/canonical_peer_priority_hash_top.sv
// Top level of the canonical peer priority hash: input register, ordering and
// CRC logic, result register. Depends on cpph_pkg, cpph_order and cpph_crc.
//
//   channel   handshake             payload
//   request   req_valid/req_stall   is_ipv6, addr_a_hi/lo, port_a, addr_b_hi/lo, port_b
//   result    res_valid/res_stall   priority_res
//
// One request per cycle while req_stall is low. A taken request waits in the input
// register, then its result is registered in the result register when that one
// can advance. The two registers lie around the ordering, masking and CRC XOR
// network.
// Reset empties both registers. A stalled result holds; a request is still
// taken while the input register is empty or moves on in the same cycle.
module canonical_peer_priority_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        is_ipv6,
  input  logic [63:0] addr_a_hi,
  input  logic [63:0] addr_a_lo,
  input  logic [15:0] port_a,
  input  logic [63:0] addr_b_hi,
  input  logic [63:0] addr_b_lo,
  input  logic [15:0] port_b,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [31:0] priority_res
);
  import cpph_pkg::*;

  logic        s1_valid;
  logic        s1_ipv6;
  logic [63:0] s1_a_hi, s1_a_lo, s1_b_hi, s1_b_lo;
  logic [15:0] s1_port_a, s1_port_b;
  logic        advance, load;
  hash_req_t   hreq;
  logic [31:0] crc;

  assign advance   = !res_valid || !res_stall;
  assign load      = !s1_valid || advance;
  assign req_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && req_valid) begin
      s1_ipv6   <= is_ipv6;
      s1_a_hi   <= addr_a_hi;
      s1_a_lo   <= addr_a_lo;
      s1_port_a <= port_a;
      s1_b_hi   <= addr_b_hi;
      s1_b_lo   <= addr_b_lo;
      s1_port_b <= port_b;
    end
  end

  cpph_order u_order (
    .is_ipv6   (s1_ipv6),
    .addr_a_hi (s1_a_hi),
    .addr_a_lo (s1_a_lo),
    .port_a    (s1_port_a),
    .addr_b_hi (s1_b_hi),
    .addr_b_lo (s1_b_lo),
    .port_b    (s1_port_b),
    .req       (hreq)
  );

  cpph_crc u_crc (
    .req (hreq),
    .crc (crc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      priority_res <= crc;
    end
  end

`ifndef ASSERT_OFF
  a_take_fills_s1: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> s1_valid)
    else $error("accepted request did not reach the input register");

  a_s1_moves_on: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> res_valid)
    else $error("pending request did not reach the result register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && res_valid && res_stall)
    else $error("request stalled while the pipeline had room");
`endif

endmodule
